// ===== rtl/cmfs_pkg.sv =====
// ----------------------------------------------------------------------------
// Cube-map face select: shared types and constants
// Widths, face codes, the records that move down the divider chain and the result record.
// ----------------------------------------------------------------------------
package cmfs_pkg;

    // Direction component width (two's complement) and face coordinate width.
    localparam int COORD_WIDTH = 16;
    localparam int UV_WIDTH    = 16;

    // Face code width and derived datapath widths.
    localparam int FACE_W  = 3;
    localparam int NUM_W   = COORD_WIDTH + 1;   // c + m and 2m
    localparam int TRIAL_W = COORD_WIDTH + 2;   // doubled remainder

    // Stream packing.
    localparam int IN_FIELDS_W  = 3 * COORD_WIDTH;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = FACE_W + 2 * UV_WIDTH;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Coordinate of a zero vector and the saturated value of 1.0.
    localparam logic [UV_WIDTH-1:0] UV_HALF = {1'b1, {(UV_WIDTH-1){1'b0}}};
    localparam logic [UV_WIDTH-1:0] UV_MAX  = {UV_WIDTH{1'b1}};

    typedef enum logic [FACE_W-1:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } face_t;

    // One request in flight through the divider chain. Each lane holds a
    // partial remainder and the quotient bits produced so far.
    typedef struct packed {
        face_t               face;
        logic                degenerate;
        logic [NUM_W-1:0]    divisor;
        logic [NUM_W-1:0]    rem_u;
        logic [NUM_W-1:0]    rem_v;
        logic                sat_u;
        logic                sat_v;
        logic [UV_WIDTH-1:0] quo_u;
        logic [UV_WIDTH-1:0] quo_v;
    } cmfs_work_t;

    // A finished result as it leaves the block.
    typedef struct packed {
        face_t               face;
        logic [UV_WIDTH-1:0] coord_u;
        logic [UV_WIDTH-1:0] coord_v;
        logic                degenerate;
    } cmfs_result_t;

endpackage

// ===== rtl/cmfs_front.sv =====
// ----------------------------------------------------------------------------
// Cube-map face select: front stage
// Picks the major axis, the face and the two signed coordinate sources, and
// sets up numerator and divisor for the divider chain.
// ----------------------------------------------------------------------------
module cmfs_front
    import cmfs_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [COORD_WIDTH-1:0] dir_x,
    input  logic [COORD_WIDTH-1:0] dir_y,
    input  logic [COORD_WIDTH-1:0] dir_z,
    output logic                   out_valid,
    output cmfs_work_t             out_work
);

    logic signed [COORD_WIDTH:0]   xe, ye, ze, nx, ny, nz;
    logic signed [COORD_WIDTH:0]   ax_w, ay_w, az_w;
    logic        [COORD_WIDTH-1:0] ax, ay, az, m;
    logic signed [COORD_WIDTH:0]   cu, cv;
    logic        [COORD_WIDTH+1:0] sum_u, sum_v;
    logic                          sel_y, sel_z, x_pos, y_pos, z_pos;
    logic                          valid_reg;
    cmfs_work_t                    work_reg, work_next;

    // Sign-extend by one bit so that the most negative value negates exactly.
    always_comb begin
        xe   = {dir_x[COORD_WIDTH-1], dir_x};
        ye   = {dir_y[COORD_WIDTH-1], dir_y};
        ze   = {dir_z[COORD_WIDTH-1], dir_z};
        nx   = -xe;
        ny   = -ye;
        nz   = -ze;
        ax_w = xe[COORD_WIDTH] ? nx : xe;
        ay_w = ye[COORD_WIDTH] ? ny : ye;
        az_w = ze[COORD_WIDTH] ? nz : ze;
        ax   = ax_w[COORD_WIDTH-1:0];
        ay   = ay_w[COORD_WIDTH-1:0];
        az   = az_w[COORD_WIDTH-1:0];
        x_pos = !xe[COORD_WIDTH] && (xe != '0);
        y_pos = !ye[COORD_WIDTH] && (ye != '0);
        z_pos = !ze[COORD_WIDTH] && (ze != '0);
        sel_z = (az >= ax) && (az >= ay);
        sel_y = (ay >= ax) && (ay >= az);
    end

    // Major axis select: on equal magnitudes Z beats Y and Y beats X.
    always_comb begin
        work_next = '0;
        m  = ax;
        cu = ze;
        cv = ye;
        priority if (sel_z) begin
            m  = az;
            cv = ye;
            if (z_pos) begin
                work_next.face = FACE_POS_Z;
                cu             = xe;
            end else begin
                work_next.face = FACE_NEG_Z;
                cu             = nx;
            end
        end else if (sel_y) begin
            m  = ay;
            cu = xe;
            if (y_pos) begin
                work_next.face = FACE_POS_Y;
                cv             = nz;
            end else begin
                work_next.face = FACE_NEG_Y;
                cv             = ze;
            end
        end else begin
            m  = ax;
            cv = ye;
            if (x_pos) begin
                work_next.face = FACE_POS_X;
                cu             = nz;
            end else begin
                work_next.face = FACE_NEG_X;
                cu             = ze;
            end
        end

        // Numerators c + m lie in 0..2m; the divisor is 2m.
        sum_u = {cu[COORD_WIDTH], cu} + {2'b00, m};
        sum_v = {cv[COORD_WIDTH], cv} + {2'b00, m};
        work_next.divisor    = {m, 1'b0};
        work_next.rem_u      = sum_u[NUM_W-1:0];
        work_next.rem_v      = sum_v[NUM_W-1:0];
        work_next.sat_u      = (sum_u[NUM_W-1:0] == {m, 1'b0});
        work_next.sat_v      = (sum_v[NUM_W-1:0] == {m, 1'b0});
        work_next.degenerate = (m == '0);
        work_next.quo_u      = '0;
        work_next.quo_v      = '0;
    end

    // Stage register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

// ===== rtl/cmfs_div_cell.sv =====
// ----------------------------------------------------------------------------
// Cube-map face select: divider cell
// One restoring-division step on both coordinate lanes; produces one
// quotient bit per lane and passes the request to the next cell.
// ----------------------------------------------------------------------------
module cmfs_div_cell
    import cmfs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic       in_valid,
    input  cmfs_work_t in_work,
    output logic       out_valid,
    output cmfs_work_t out_work
);

    logic [TRIAL_W-1:0] trial_u, trial_v, dsr, diff_u, diff_v;
    logic               bit_u, bit_v;
    logic               valid_reg;
    cmfs_work_t         work_reg, work_next;

    // Double the remainder, subtract the divisor when it fits.
    always_comb begin
        dsr     = {1'b0, in_work.divisor};
        trial_u = {in_work.rem_u, 1'b0};
        trial_v = {in_work.rem_v, 1'b0};
        diff_u  = trial_u - dsr;
        diff_v  = trial_v - dsr;
        bit_u   = (trial_u >= dsr);
        bit_v   = (trial_v >= dsr);

        work_next       = in_work;
        work_next.rem_u = bit_u ? diff_u[NUM_W-1:0] : trial_u[NUM_W-1:0];
        work_next.rem_v = bit_v ? diff_v[NUM_W-1:0] : trial_v[NUM_W-1:0];
        work_next.quo_u = {in_work.quo_u[UV_WIDTH-2:0], bit_u};
        work_next.quo_v = {in_work.quo_v[UV_WIDTH-2:0], bit_v};
    end

    // Cell register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

// ===== rtl/cube_map_face_select.sv =====
// ----------------------------------------------------------------------------
// Cube-map face select: top level
// Direction vector in, cube face and face coordinates out.
// ----------------------------------------------------------------------------
// The block takes one direction request per cycle while s_tready is high and
// returns one result per request, in order. A request passes the major-axis
// stage register, one register per cell of the divider chain (each cell
// resolves one quotient bit for both u and v) and the output register. A
// two-entry output buffer lets input continue while a result waits, so
// s_tready drops only after the output is stalled while a further result
// reaches the end of the chain.
module cube_map_face_select
    import cmfs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // dir_x, dir_y, dir_z from the lowest bit up
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // face, coord_u, coord_v from the lowest bit up, zero padded
    output logic [OUT_DATA_W-1:0] m_tdata,
    // degenerate
    output logic                  m_tuser
);

    logic         en;
    logic         stage_valid [UV_WIDTH+1];
    cmfs_work_t   stage_work  [UV_WIDTH+1];
    logic         push;
    cmfs_result_t pipe_result;
    logic         out_valid_reg, skid_valid_reg;
    cmfs_result_t out_reg, skid_reg;

    // The chain advances whenever the skid entry is free.
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // Major-axis stage.
    cmfs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .dir_x     (s_tdata[0 +: COORD_WIDTH]),
        .dir_y     (s_tdata[COORD_WIDTH +: COORD_WIDTH]),
        .dir_z     (s_tdata[2*COORD_WIDTH +: COORD_WIDTH]),
        .out_valid (stage_valid[0]),
        .out_work  (stage_work[0])
    );

    // Divider chain, one quotient bit per cell.
    for (genvar i = 0; i < UV_WIDTH; i++) begin : g_cell
        cmfs_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (stage_valid[i]),
            .in_work   (stage_work[i]),
            .out_valid (stage_valid[i+1]),
            .out_work  (stage_work[i+1])
        );
    end

    // Final selection: zero vector, saturated 1.0, or the quotient.
    always_comb begin
        pipe_result.face       = stage_work[UV_WIDTH].face;
        pipe_result.degenerate = stage_work[UV_WIDTH].degenerate;
        priority if (stage_work[UV_WIDTH].degenerate) begin
            pipe_result.coord_u = UV_HALF;
            pipe_result.coord_v = UV_HALF;
        end else begin
            pipe_result.coord_u = stage_work[UV_WIDTH].sat_u ? UV_MAX
                                                             : stage_work[UV_WIDTH].quo_u;
            pipe_result.coord_v = stage_work[UV_WIDTH].sat_v ? UV_MAX
                                                             : stage_work[UV_WIDTH].quo_v;
        end
    end

    assign push = en && stage_valid[UV_WIDTH];

    // Output register with skid entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_tready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (push) begin
                out_reg <= pipe_result;
            end
        end else if (push) begin
            skid_reg <= pipe_result;
        end
    end

    // Output packing.
    always_comb begin
        m_tdata                               = '0;
        m_tdata[0 +: FACE_W]                  = out_reg.face;
        m_tdata[FACE_W +: UV_WIDTH]           = out_reg.coord_u;
        m_tdata[FACE_W + UV_WIDTH +: UV_WIDTH] = out_reg.coord_v;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.degenerate;

`ifndef SYNTHESIS
    // The skid entry is only ever occupied behind a valid output.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a request while the output is empty");

    // The skid entry fills only when the output was stalled.
    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid entry filled without an output stall");

    // A zero vector always leaves as face -Z at the center of the face.
    a_degenerate_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |->
            (out_reg.face == FACE_NEG_Z) && (out_reg.coord_u == UV_HALF)
            && (out_reg.coord_v == UV_HALF))
        else $error("degenerate result with wrong face or coordinates");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cube-map face select: self-checking testbench
// Sends direction requests over the input stream and compares every result's
// face, face coordinates and degenerate flag with the values given in the
// directed table or with a built-in predictor. The directed table comes first,
// then random requests under varying idle and back-pressure patterns.
// ----------------------------------------------------------------------------
module testbench
    import cmfs_pkg::*;
();

    localparam int LATENCY       = UV_WIDTH + 2;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int SEGMENTS      = 8;
    localparam int HOLD_CYCLES   = 120;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int MAX_PRINTED   = 50;
    localparam int TABLE_ROWS    = 25;

    // Idle patterns applied to the two sides of the block.
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // One row of the directed table. When known is set, the expected result
    // is given in the row; otherwise it comes from the predictor.
    typedef struct packed {
        logic [COORD_WIDTH-1:0] x;
        logic [COORD_WIDTH-1:0] y;
        logic [COORD_WIDTH-1:0] z;
        logic                   known;
        face_t                  face;
        logic [UV_WIDTH-1:0]    u;
        logic [UV_WIDTH-1:0]    v;
        logic                   deg;
    } dir_row_t;

    localparam dir_row_t DIR_TABLE [TABLE_ROWS] = '{
        // Zero vector, single-axis extremes and three-way ties.
        '{16'd0, 16'd0, 16'd0, 1'b1, FACE_NEG_Z, 16'h8000, 16'h8000, 1'b1},
        '{16'h7FFF, 16'd0, 16'd0, 1'b1, FACE_POS_X, 16'h8000, 16'h8000, 1'b0},
        '{16'h8000, 16'd0, 16'd0, 1'b1, FACE_NEG_X, 16'h8000, 16'h8000, 1'b0},
        '{16'd0, 16'h7FFF, 16'd0, 1'b1, FACE_POS_Y, 16'h8000, 16'h8000, 1'b0},
        '{16'd0, 16'h8000, 16'd0, 1'b1, FACE_NEG_Y, 16'h8000, 16'h8000, 1'b0},
        '{16'd0, 16'd0, 16'h7FFF, 1'b1, FACE_POS_Z, 16'h8000, 16'h8000, 1'b0},
        '{16'd0, 16'd0, 16'h8000, 1'b1, FACE_NEG_Z, 16'h8000, 16'h8000, 1'b0},
        '{16'd100, 16'd100, 16'd100, 1'b1, FACE_POS_Z, 16'hFFFF, 16'hFFFF, 1'b0},
        '{-16'sd100, -16'sd100, -16'sd100, 1'b1, FACE_NEG_Z, 16'hFFFF, 16'h0000, 1'b0},
        '{16'h8000, 16'h8000, 16'h8000, 1'b1, FACE_NEG_Z, 16'hFFFF, 16'h0000, 1'b0},
        '{16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, FACE_POS_Z, 16'hFFFF, 16'hFFFF, 1'b0},
        // Every face with off-axis content, two-way ties, mixed extremes.
        '{16'd1000, 16'd10, -16'sd20, 1'b0, FACE_POS_X, 16'd0, 16'd0, 1'b0},
        '{-16'sd1000, 16'd300, 16'd400, 1'b0, FACE_POS_X, 16'd0, 16'd0, 1'b0},
        '{16'd10, 16'd1000, -16'sd5, 1'b0, FACE_POS_X, 16'd0, 16'd0, 1'b0},
        '{16'd10, -16'sd1000, 16'd5, 1'b0, FACE_POS_X, 16'd0, 16'd0, 1'b0},
        '{-16'sd7, 16'd3, 16'd900, 1'b0, FACE_POS_X, 16'd0, 16'd0, 1'b0},
        '{16'd7, -16'sd3, -16'sd900, 1'b0, FACE_POS_X, 16'd0, 16'd0, 1'b0},
        '{16'd200, 16'd200, 16'd50, 1'b0, FACE_POS_X, 16'd0, 16'd0, 1'b0},
        '{-16'sd300, 16'd300, 16'd0, 1'b0, FACE_POS_X, 16'd0, 16'd0, 1'b0},
        '{16'd5, -16'sd400, 16'd400, 1'b0, FACE_POS_X, 16'd0, 16'd0, 1'b0},
        '{16'h7FFF, 16'h8000, 16'd1, 1'b0, FACE_POS_X, 16'd0, 16'd0, 1'b0},
        '{16'h8000, 16'h7FFF, 16'hFFFF, 1'b0, FACE_POS_X, 16'd0, 16'd0, 1'b0},
        '{16'hFFFF, 16'd0, 16'd0, 1'b0, FACE_POS_X, 16'd0, 16'd0, 1'b0},
        '{16'd1, 16'd1, 16'd0, 1'b0, FACE_POS_X, 16'd0, 16'd0, 1'b0},
        '{16'd0, 16'hFFFF, 16'hFFFF, 1'b0, FACE_POS_X, 16'd0, 16'd0, 1'b0}
    };

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // dir_x, dir_y, dir_z from the lowest bit up
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // face, coord_u, coord_v from the lowest bit up, zero padded
    logic [OUT_DATA_W-1:0] m_tdata;
    // degenerate
    logic                  m_tuser;

    idle_mode_t   idle_mode     = IDLE_NONE;
    int           hold_requests = 0;
    int           holds_served  = 0;
    int           hold_left     = 0;
    int           error_count   = 0;
    int           cycle_count   = 0;
    cmfs_result_t face_expected [$];

    cube_map_face_select u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    function automatic bit chance(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic int sender_idle_pct();
        case (idle_mode)
            IDLE_SENDER: return 86;
            IDLE_BOTH:   return 24;
            default:     return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct();
        case (idle_mode)
            IDLE_RECEIVER: return 86;
            IDLE_BOTH:     return 24;
            default:       return 0;
        endcase
    endfunction

    // Truncated fraction (c + m) / 2m of 2^UV_WIDTH, with 1.0 saturated.
    function automatic logic [UV_WIDTH-1:0] uv_fraction(longint c, longint m);
        longint q;
        q = ((c + m) <<< UV_WIDTH) / (2 * m);
        if (q > longint'(UV_MAX))
            q = longint'(UV_MAX);
        return q[UV_WIDTH-1:0];
    endfunction

    // Major-axis selection and face coordinates. Later tests win ties, so Z
    // beats Y and Y beats X; a zero major component selects the negative face.
    function automatic cmfs_result_t predict_face_uv(logic signed [COORD_WIDTH-1:0] x,
                                                     logic signed [COORD_WIDTH-1:0] y,
                                                     logic signed [COORD_WIDTH-1:0] z);
        longint sx, sy, sz, ax, ay, az, m, cu, cv;
        cmfs_result_t r;
        sx = x;
        sy = y;
        sz = z;
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        az = (sz < 0) ? -sz : sz;
        m  = 0;
        cu = 0;
        cv = 0;
        r.face = FACE_NEG_Z;
        if (ax >= ay && ax >= az) begin
            m  = ax;
            cv = sy;
            if (sx > 0) begin
                r.face = FACE_POS_X;
                cu = -sz;
            end else begin
                r.face = FACE_NEG_X;
                cu = sz;
            end
        end
        if (ay >= ax && ay >= az) begin
            m  = ay;
            cu = sx;
            if (sy > 0) begin
                r.face = FACE_POS_Y;
                cv = -sz;
            end else begin
                r.face = FACE_NEG_Y;
                cv = sz;
            end
        end
        if (az >= ax && az >= ay) begin
            m  = az;
            cv = sy;
            if (sz > 0) begin
                r.face = FACE_POS_Z;
                cu = sx;
            end else begin
                r.face = FACE_NEG_Z;
                cu = -sx;
            end
        end
        if (m == 0) begin
            r.coord_u    = UV_HALF;
            r.coord_v    = UV_HALF;
            r.degenerate = 1'b1;
        end else begin
            r.coord_u    = uv_fraction(cu, m);
            r.coord_v    = uv_fraction(cv, m);
            r.degenerate = 1'b0;
        end
        return r;
    endfunction

    // Random direction: full-range values, tiny values, ties with random
    // signs, extreme values and values of widely varying magnitude.
    function automatic logic [IN_DATA_W-1:0] random_direction();
        logic [COORD_WIDTH-1:0] c [3];
        logic [COORD_WIDTH-1:0] v;
        int kind;
        kind = $urandom_range(7);
        v    = COORD_WIDTH'($urandom);
        for (int i = 0; i < 3; i++) begin
            case (kind)
                2: c[i] = 16'($urandom_range(8)) - 16'd4;
                3: begin
                    if (chance(75))
                        c[i] = chance(50) ? -v : v;
                    else
                        c[i] = COORD_WIDTH'($urandom);
                end
                4: begin
                    case ($urandom_range(5))
                        0:       c[i] = 16'h8000;
                        1:       c[i] = 16'h8001;
                        2:       c[i] = 16'hFFFF;
                        3:       c[i] = 16'h0000;
                        4:       c[i] = 16'h0001;
                        default: c[i] = 16'h7FFF;
                    endcase
                end
                5: begin
                    c[i] = 16'($urandom >> $urandom_range(16, 31));
                    if (chance(50))
                        c[i] = -c[i];
                end
                default: c[i] = COORD_WIDTH'($urandom);
            endcase
        end
        return {c[2], c[1], c[0]};
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (error_count < MAX_PRINTED)
            $display("mismatch at cycle %0d: %s got %0h expected %0h",
                     cycle_count, what, got, want);
        error_count++;
    endtask

    // Offer one direction request, with random idle cycles before it, and
    // record its expected result once the block accepts it.
    task automatic send_direction(input logic [IN_DATA_W-1:0] dir, input cmfs_result_t want);
        while (chance(sender_idle_pct())) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= dir;
        do
            @(posedge aclk);
        while (!s_tready);
        face_expected.push_back(want);
    endtask

    // Sender pause until every outstanding request has returned.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (face_expected.size() != 0)
            @(posedge aclk);
    endtask

    // Receiver ready: random stalls per idle mode, or a long hold-off.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != hold_requests) begin
            holds_served <= hold_requests;
            hold_left    <= HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= !chance(receiver_idle_pct());
        end
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge aclk) begin : check_results
        cmfs_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (face_expected.size() == 0) begin
                report_mismatch("result with no request pending", m_tdata, 0);
            end else begin
                want = face_expected.pop_front();
                if (m_tdata[FACE_W-1:0] != want.face)
                    report_mismatch("face", m_tdata[FACE_W-1:0], want.face);
                if (m_tdata[FACE_W +: UV_WIDTH] != want.coord_u)
                    report_mismatch("coord_u", m_tdata[FACE_W +: UV_WIDTH], want.coord_u);
                if (m_tdata[FACE_W + UV_WIDTH +: UV_WIDTH] != want.coord_v)
                    report_mismatch("coord_v", m_tdata[FACE_W + UV_WIDTH +: UV_WIDTH],
                                    want.coord_v);
                if (m_tdata[OUT_DATA_W-1:OUT_FIELDS_W] != '0)
                    report_mismatch("padding", m_tdata[OUT_DATA_W-1:OUT_FIELDS_W], 0);
                if (m_tuser != want.degenerate)
                    report_mismatch("degenerate", m_tuser, want.degenerate);
            end
        end
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus: reset, directed table, then random segments.
    initial begin : stimulus
        dir_row_t               row;
        cmfs_result_t           want;
        logic [IN_DATA_W-1:0]   dir;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table with no idling.
        for (int i = 0; i < TABLE_ROWS; i++) begin
            row = DIR_TABLE[i];
            dir = {row.z, row.y, row.x};
            if (row.known) begin
                want.face       = row.face;
                want.coord_u    = row.u;
                want.coord_v    = row.v;
                want.degenerate = row.deg;
            end else begin
                want = predict_face_uv(row.x, row.y, row.z);
            end
            send_direction(dir, want);
        end
        drain_results();

        // Random segments cycle through the idle modes. Two of them start
        // with a long receiver hold-off while requests keep coming.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            idle_mode = idle_mode_t'(seg % 4);
            if (seg == 0 || seg == 5)
                hold_requests++;
            for (int n = 0; n < RANDOM_ITEMS / SEGMENTS; n++) begin
                dir = random_direction();
                send_direction(dir, predict_face_uv(dir[COORD_WIDTH-1:0],
                                                    dir[2*COORD_WIDTH-1:COORD_WIDTH],
                                                    dir[3*COORD_WIDTH-1:2*COORD_WIDTH]));
            end
            drain_results();
        end

        repeat (LATENCY + 16) @(posedge aclk);
        if (error_count == 0 && face_expected.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
